[rtl/bta_pkg.sv]
package bta_pkg;

   localparam int OPCODE_W = 2;
   localparam int REQ_W    = 11;
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 11;
   localparam int NODE_W   = 5;
   localparam int NEED_W   = $clog2(REQ_W + 1);

   localparam logic [COUNT_W-1:0] UNIT_COUNT_RESET = 11'd1024;

   localparam logic [NODE_W-1:0] FREE_MARK = 5'd0;
   localparam logic [NODE_W-1:0] USED_MARK = 5'd31;

   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;

   // ceil(log2(count)), 0 for counts of zero and one
   function automatic logic [NEED_W-1:0] levels_for(input logic [REQ_W-1:0] count);
      logic [REQ_W-1:0]  m;
      logic [NEED_W-1:0] r;
      m = count - REQ_W'(1);
      r = '0;
      if (count > REQ_W'(1)) begin
         for (int i = 0; i < REQ_W; i++) begin
            if (m[i]) begin
               r = NEED_W'(i + 1);
            end
         end
      end
      return r;
   endfunction

endpackage

[rtl/bta_if.sv]
interface bta_req_if;
   logic                           valid;
   logic                           ready;
   logic [bta_pkg::OPCODE_W-1:0]   opcode;
   logic [bta_pkg::REQ_W-1:0]      request_units;
   logic [bta_pkg::OFFSET_W-1:0]   offset;

   modport source (output valid, output opcode, output request_units, output offset,
                   input ready);
   modport sink   (input valid, input opcode, input request_units, input offset,
                   output ready);
endinterface

interface bta_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [bta_pkg::OFFSET_W-1:0]   block_offset;

   modport source (output valid, output status, output block_offset, input ready);
   modport sink   (input valid, input status, input block_offset, output ready);
endinterface

interface bta_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bta_pkg::COUNT_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/bta_ram.sv]
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[rtl/buddy_tree_allocator.sv]
// Binary buddy allocator. Opcode 0 allocates request_units rounded up to a power of two
// and returns the first unit of the block, opcode 1 frees the block that holds unit
// offset, opcode 2 rebuilds the tree for csr unit_count (padding units marked used).
// Every item gives exactly one result. The tree lives in a single RAM with one write
// and two read ports; each tree level takes a read, then a compare/write. Allocate
// descends until neither child can hold the block, then repairs the ancestors; free
// climbs to the used node and repairs above it, so it covers one path once. Repair
// stops early where an ancestor already holds the new value. Init first sweeps
// 2<<levels entries at one per cycle, then marks each padding unit with its own repair
// walk. After reset the block clears the whole tree, 2<<MAX_LEVELS entries (2048 by
// default), before it takes an item. The next item may be taken while the previous
// result waits on rsp_chan.
module buddy_tree_allocator #(
   parameter int MAX_LEVELS = 10
) (
   input  logic      clock,
   input  logic      reset,
   bta_req_if.sink   req_chan,
   bta_rsp_if.source rsp_chan,
   bta_csr_if.sink   csr_chan
);

   localparam int NodeW = MAX_LEVELS + 1;
   localparam int Depth = 2 << MAX_LEVELS;
   localparam int LvlW  = $clog2(MAX_LEVELS + 1);
   localparam int CntW  = (MAX_LEVELS + 1 > bta_pkg::COUNT_W) ? MAX_LEVELS + 1
                                                              : bta_pkg::COUNT_W;
   localparam int CmpW  = 6;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_AROOT  = 4'd2;
   localparam logic [3:0] S_ADESC  = 4'd3;
   localparam logic [3:0] S_ADCHK  = 4'd4;
   localparam logic [3:0] S_FUP    = 4'd5;
   localparam logic [3:0] S_FCHK   = 4'd6;
   localparam logic [3:0] S_SET    = 4'd7;
   localparam logic [3:0] S_RISSUE = 4'd8;
   localparam logic [3:0] S_RCHK   = 4'd9;
   localparam logic [3:0] S_PAD    = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]                      state_ff, state_in;
   logic [NodeW-1:0]                node_ff, node_in;
   logic [bta_pkg::NODE_W-1:0]      val_ff, val_in;
   logic [LvlW-1:0]                 h_ff, h_in;
   logic [bta_pkg::NEED_W-1:0]      need_ff, need_in;
   logic [MAX_LEVELS-1:0]           off_ff, off_in;
   logic [LvlW-1:0]                 levels_ff, levels_in;
   logic [NodeW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [NodeW-1:0]                clr_last_ff, clr_last_in;
   logic [NodeW-1:0]                pad_ff, pad_in;
   logic [bta_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic                            status_ff, status_in;
   logic [bta_pkg::COUNT_W-1:0]     unit_count_ff, unit_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic [bta_pkg::OFFSET_W-1:0]    rsp_offset_ff, rsp_offset_in;

   logic                            req_fire;
   logic                            rsp_load;
   logic [NodeW-1:0]                leaves;
   logic [NodeW-1:0]                child_l, child_r, parent, sibling;
   logic [CntW-1:0]                 c_ext, c_cap, c_sat;
   logic [LvlW-1:0]                 lv_new;
   logic [bta_pkg::NODE_W-1:0]      u_val, v_val, min_val, w_val;
   logic [CmpW-1:0]                 h_cmp, root_need, l_need, r_need;

   logic                            ram_wr_en;
   logic [NodeW-1:0]                ram_wr_addr;
   logic [bta_pkg::NODE_W-1:0]      ram_wr_data;
   logic [NodeW-1:0]                ram_rd_addr_a, ram_rd_addr_b;
   logic [bta_pkg::NODE_W-1:0]      ram_rd_data_a, ram_rd_data_b;

   bta_ram #(
      .WIDTH (bta_pkg::NODE_W),
      .DEPTH (Depth)
   ) u_tree (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.block_offset = rsp_offset_ff;

   assign req_fire = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign leaves  = NodeW'(1) << levels_ff;
   assign child_l = {node_ff[NodeW-2:0], 1'b1};
   assign child_r = child_l + NodeW'(1);
   assign parent  = (node_ff - NodeW'(1)) >> 1;
   assign sibling = node_ff[0] ? node_ff + NodeW'(1) : node_ff - NodeW'(1);

   assign c_ext  = CntW'(unit_count_ff);
   assign c_cap  = CntW'(1) << MAX_LEVELS;
   assign c_sat  = (c_ext > c_cap) ? c_cap : c_ext;
   assign lv_new = LvlW'(bta_pkg::levels_for(bta_pkg::REQ_W'(c_sat)));

   // repair: the node just written is one child, the RAM gives its sibling
   assign u_val   = node_ff[0] ? val_ff : ram_rd_data_a;
   assign v_val   = node_ff[0] ? ram_rd_data_a : val_ff;
   assign min_val = (u_val < v_val) ? u_val : v_val;
   assign w_val   = ((u_val == v_val) &&
                     ((u_val == bta_pkg::FREE_MARK) || (u_val == bta_pkg::USED_MARK)))
                    ? u_val : min_val + bta_pkg::NODE_W'(1);

   assign h_cmp     = CmpW'(h_ff);
   assign root_need = CmpW'(need_ff) + CmpW'(ram_rd_data_a);
   assign l_need    = CmpW'(need_ff) + CmpW'(ram_rd_data_a);
   assign r_need    = CmpW'(need_ff) + CmpW'(ram_rd_data_b);

   always_comb begin
      ram_rd_addr_a = '0;
      ram_rd_addr_b = '0;
      unique case (state_ff)
         S_ADESC: begin
            ram_rd_addr_a = child_l;
            ram_rd_addr_b = child_r;
         end
         S_FUP: begin
            ram_rd_addr_a = node_ff;
         end
         S_RISSUE: begin
            ram_rd_addr_a = sibling;
            ram_rd_addr_b = parent;
         end
         default: begin
            ram_rd_addr_a = '0;
            ram_rd_addr_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      val_in        = val_ff;
      h_in          = h_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      levels_in     = levels_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_last_in   = clr_last_ff;
      pad_in        = pad_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      unit_count_in = unit_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = node_ff;
      ram_wr_data   = val_ff;

      if (csr_chan.valid) begin
         unit_count_in = csr_chan.data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = bta_pkg::FREE_MARK;
            clr_cnt_in  = clr_cnt_ff + NodeW'(1);
            if (clr_cnt_ff == clr_last_ff) begin
               state_in = (op_ff == bta_pkg::OP_INIT) ? S_PAD : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.opcode;
               off_in    = '0;
               status_in = 1'b1;
               unique case (req_chan.opcode)
                  bta_pkg::OP_ALLOC: begin
                     node_in  = '0;
                     h_in     = levels_ff;
                     need_in  = bta_pkg::levels_for(req_chan.request_units);
                     state_in = S_AROOT;
                  end
                  bta_pkg::OP_FREE: begin
                     if (CntW'(req_chan.offset) >= (CntW'(1) << levels_ff)) begin
                        state_in = S_DONE;
                     end else begin
                        node_in  = NodeW'(req_chan.offset) + leaves - NodeW'(1);
                        state_in = S_FUP;
                     end
                  end
                  bta_pkg::OP_INIT: begin
                     levels_in   = lv_new;
                     clr_cnt_in  = '0;
                     clr_last_in = {NodeW{1'b1}} >> (LvlW'(MAX_LEVELS) - lv_new);
                     pad_in      = NodeW'(c_sat);
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_AROOT: begin
            if (h_cmp < root_need) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ADESC;
            end
         end
         S_ADESC: begin
            if (h_ff == '0) begin
               val_in   = bta_pkg::USED_MARK;
               state_in = S_SET;
            end else begin
               state_in = S_ADCHK;
            end
         end
         S_ADCHK: begin
            // left first, stop where neither child can hold the block
            priority if (h_cmp > l_need) begin
               node_in  = child_l;
               h_in     = h_ff - LvlW'(1);
               state_in = S_ADESC;
            end else if (h_cmp > r_need) begin
               node_in  = child_r;
               h_in     = h_ff - LvlW'(1);
               off_in   = off_ff + (MAX_LEVELS'(1) << (h_ff - LvlW'(1)));
               state_in = S_ADESC;
            end else begin
               val_in   = bta_pkg::USED_MARK;
               state_in = S_SET;
            end
         end
         S_FUP: begin
            if (node_ff == '0) begin
               val_in   = bta_pkg::FREE_MARK;
               state_in = S_SET;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (ram_rd_data_a == bta_pkg::USED_MARK) begin
               val_in   = bta_pkg::FREE_MARK;
               state_in = S_SET;
            end else begin
               node_in  = parent;
               state_in = S_FUP;
            end
         end
         S_SET: begin
            ram_wr_en = 1'b1;
            state_in  = S_RISSUE;
         end
         S_RISSUE: begin
            if (node_ff == '0) begin
               if (op_ff == bta_pkg::OP_INIT) begin
                  pad_in   = pad_ff + NodeW'(1);
                  state_in = S_PAD;
               end else begin
                  status_in = 1'b0;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_RCHK;
            end
         end
         S_RCHK: begin
            if (ram_rd_data_b == w_val) begin
               if (op_ff == bta_pkg::OP_INIT) begin
                  pad_in   = pad_ff + NodeW'(1);
                  state_in = S_PAD;
               end else begin
                  status_in = 1'b0;
                  state_in  = S_DONE;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = parent;
               ram_wr_data = w_val;
               node_in     = parent;
               val_in      = w_val;
               state_in    = S_RISSUE;
            end
         end
         S_PAD: begin
            if (pad_ff >= leaves) begin
               status_in = 1'b0;
               state_in  = S_DONE;
            end else begin
               node_in  = pad_ff + leaves - NodeW'(1);
               val_in   = bta_pkg::USED_MARK;
               state_in = S_SET;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_offset_in = bta_pkg::OFFSET_W'(off_ff);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         clr_last_ff   <= {NodeW{1'b1}};
         levels_ff     <= LvlW'(MAX_LEVELS);
         op_ff         <= bta_pkg::OP_ALLOC;
         unit_count_ff <= bta_pkg::UNIT_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_last_ff   <= clr_last_in;
         levels_ff     <= levels_in;
         op_ff         <= op_in;
         unit_count_ff <= unit_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      val_ff        <= val_in;
      h_ff          <= h_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      pad_ff        <= pad_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   a_levels_bound: assert property (@(posedge clock) disable iff (reset)
      levels_ff <= LvlW'(MAX_LEVELS))
      else $error("tree height above MAX_LEVELS");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item taken while another is in flight");

   a_alloc_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && op_ff == bta_pkg::OP_ALLOC && !status_ff)
         |-> (NodeW'(off_ff) < leaves))
      else $error("allocated block starts outside the tree");

   a_repair_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RISSUE) |-> (node_ff <= ((leaves << 1) - NodeW'(2))))
      else $error("repair walk left the tree");

endmodule

[verif/tb_buddy_tree_allocator.sv]
module tb_buddy_tree_allocator;

   localparam int TREE_LEVELS = 10;
   localparam int NODE_COUNT  = 2 << TREE_LEVELS;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam logic [bta_pkg::OPCODE_W-1:0] OP_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [bta_pkg::OPCODE_W-1:0] opcode;
      logic [bta_pkg::REQ_W-1:0]    request_units;
      logic [bta_pkg::OFFSET_W-1:0] offset;
   } alloc_cmd_type;

   typedef struct packed {
      logic                         status;
      logic [bta_pkg::OFFSET_W-1:0] block_offset;
   } alloc_grant_type;

   logic clock;
   logic reset;

   bta_req_if req_chan ();
   bta_rsp_if rsp_chan ();
   bta_csr_if csr_chan ();

   buddy_tree_allocator #(.MAX_LEVELS(TREE_LEVELS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow copy of the allocator state
   logic [bta_pkg::NODE_W-1:0]  shadow_tree [NODE_COUNT];
   int                          shadow_levels;
   logic [bta_pkg::COUNT_W-1:0] shadow_units;
   int                          live_offsets[$];   // blocks believed to be allocated

   alloc_cmd_type   pending_reqs[$];
   alloc_grant_type expected_grants[$];
   alloc_cmd_type   in_flight;

   int  items_queued, results_seen, mismatches, cycles;
   int  alloc_total, alloc_granted, free_total, free_ok, init_total, undef_total;
   int  settings_used;
   int  send_gap, ready_hold;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int ceil_height(int count);
      int d;
      d = 0;
      while (count >= 2) begin
         count = (count + 1) / 2;
         d++;
      end
      return d;
   endfunction

   function automatic void repair_ancestors(int n);
      int u, v, w;
      while (n != 0) begin
         n = (n - 1) / 2;
         u = int'(shadow_tree[2*n+1]);
         v = int'(shadow_tree[2*n+2]);
         w = ((u < v) ? u : v) + 1;
         if (u == v && (u == int'(bta_pkg::FREE_MARK) || u == int'(bta_pkg::USED_MARK))) begin
            w = u;
         end
         if (int'(shadow_tree[n]) == w) break;
         shadow_tree[n] = bta_pkg::NODE_W'(w);
      end
   endfunction

   function automatic void rebuild_shadow();
      int c, leaves;
      c = int'(shadow_units);
      if (c > (1 << TREE_LEVELS)) begin
         c = 1 << TREE_LEVELS;
      end
      shadow_levels = ceil_height(c);
      for (int n = 0; n < (2 << shadow_levels); n++) shadow_tree[n] = bta_pkg::FREE_MARK;
      leaves = 1 << shadow_levels;
      // padding units are marked used
      for (int o = c; o < leaves; o++) begin
         shadow_tree[o + leaves - 1] = bta_pkg::USED_MARK;
         repair_ancestors(o + leaves - 1);
      end
      live_offsets.delete();
   endfunction

   function automatic alloc_grant_type buddy_step(alloc_cmd_type cmd);
      alloc_grant_type g;
      int h, need, n, o;
      g.status       = 1'b1;
      g.block_offset = '0;
      case (cmd.opcode)
         bta_pkg::OP_ALLOC: begin
            alloc_total++;
            h    = shadow_levels;
            need = ceil_height(int'(cmd.request_units));
            n    = 0;
            if (h - int'(shadow_tree[0]) >= need) begin
               // left-first descent, stops at a leaf or where neither child can hold the block
               while (h > 0) begin
                  if (h - int'(shadow_tree[2*n+1]) > need) begin
                     n = 2*n + 1;
                     h--;
                  end else if (h - int'(shadow_tree[2*n+2]) > need) begin
                     n = 2*n + 2;
                     h--;
                  end else begin
                     break;
                  end
               end
               shadow_tree[n] = bta_pkg::USED_MARK;
               repair_ancestors(n);
               o = (((n + 1) << h) - 1) - ((1 << shadow_levels) - 1);
               g.status       = 1'b0;
               g.block_offset = bta_pkg::OFFSET_W'(o);
               live_offsets.push_back(o);
               alloc_granted++;
            end
         end
         bta_pkg::OP_FREE: begin
            free_total++;
            o = int'(cmd.offset);
            if (o < (1 << shadow_levels)) begin
               n = o + (1 << shadow_levels) - 1;
               while (n >= 1) begin
                  if (shadow_tree[n] == bta_pkg::USED_MARK) break;
                  n = (n - 1) / 2;
               end
               shadow_tree[n] = bta_pkg::FREE_MARK;
               repair_ancestors(n);
               g.status = 1'b0;
               free_ok++;
               if (n == 0) begin
                  live_offsets.delete();
               end else begin
                  for (int i = 0; i < live_offsets.size(); i++) begin
                     if (live_offsets[i] == o) begin
                        live_offsets.delete(i);
                        break;
                     end
                  end
               end
            end
         end
         bta_pkg::OP_INIT: begin
            init_total++;
            rebuild_shadow();
            g.status = 1'b0;
         end
         default: undef_total++;
      endcase
      return g;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [bta_pkg::REQ_W-1:0] pick_request_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return bta_pkg::REQ_W'($urandom_range(1, 8));
      if (r < 88) return bta_pkg::REQ_W'($urandom_range(9, 64));
      if (r < 95) return bta_pkg::REQ_W'($urandom_range(65, 1024));
      if (r < 97) return '0;
      return bta_pkg::REQ_W'($urandom_range(1025, 2047));
   endfunction

   // mostly alloc/free of live blocks, some stray frees, rare init and bad opcode
   function automatic alloc_cmd_type make_random_cmd();
      alloc_cmd_type c;
      int r, alloc_cut;
      c.opcode        = bta_pkg::OP_ALLOC;
      c.request_units = bta_pkg::REQ_W'($urandom_range(0, 2047));
      c.offset        = bta_pkg::OFFSET_W'($urandom_range(0, 1023));
      alloc_cut = (live_offsets.size() > 32) ? 35 : 58;
      r = $urandom_range(0, 99);
      if (r < 1) begin
         c.opcode = bta_pkg::OP_INIT;
      end else if (r < 2) begin
         c.opcode = OP_UNDEFINED;
      end else if (r < alloc_cut) begin
         c.request_units = pick_request_size();
      end else begin
         c.opcode = bta_pkg::OP_FREE;
         if (r < 93 && live_offsets.size() > 0) begin
            c.offset = bta_pkg::OFFSET_W'(
               live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
         end else if (r < 97) begin
            c.offset = bta_pkg::OFFSET_W'($urandom_range(0, (1 << shadow_levels) - 1));
         end
      end
      return c;
   endfunction

   function automatic void flag_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0d] result %0d %s: expected %0d, got %0d",
                  cycles, results_seen, what, want, got);
      end
   endfunction

   task automatic queue_cmd(input logic [bta_pkg::OPCODE_W-1:0] op, input int units,
                            input int off);
      alloc_cmd_type c;
      c.opcode        = op;
      c.request_units = bta_pkg::REQ_W'(units);
      c.offset        = bta_pkg::OFFSET_W'(off);
      pending_reqs.push_back(c);
      items_queued++;
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         while (pending_reqs.size() >= 2) @(posedge clock);
         pending_reqs.push_back(make_random_cmd());
         items_queued++;
      end
   endtask

   task automatic settle();
      while (results_seen != items_queued) @(posedge clock);
   endtask

   task automatic set_unit_count(input logic [bta_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      shadow_units = value;
      settings_used++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_grants.push_back(buddy_step(in_flight));
         end
         if (send_gap > 0) begin
            send_gap       <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            in_flight = pending_reqs.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.opcode        <= in_flight.opcode;
            req_chan.request_units <= in_flight.request_units;
            req_chan.offset        <= in_flight.offset;
            send_gap               <= pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin
      alloc_grant_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_hold     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_grants.size() == 0) begin
               flag_mismatch("arrived with nothing outstanding, offset", -1,
                             int'(rsp_chan.block_offset));
            end else begin
               want = expected_grants.pop_front();
               results_seen++;
               if (rsp_chan.status !== want.status) begin
                  flag_mismatch("status", int'(want.status), int'(rsp_chan.status));
               end
               if (rsp_chan.block_offset !== want.block_offset) begin
                  flag_mismatch("block_offset", int'(want.block_offset),
                                int'(rsp_chan.block_offset));
               end
            end
         end
         if (ready_hold > 0) begin
            ready_hold     <= ready_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            ready_hold     <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d of %0d results seen",
                  cycles, results_seen, items_queued);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [bta_pkg::COUNT_W-1:0] plan [10];
      logic [bta_pkg::COUNT_W-1:0] setting;
      plan = '{11'd1024, 11'd1, 11'd2, 11'd3, 11'd100, 11'd513, 11'd2047, 11'd0,
               11'd1024, 11'd1024};
      cycles = 0;
      reset  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = bta_pkg::OP_ALLOC;
      req_chan.request_units = '0;
      req_chan.offset        = '0;
      rsp_chan.ready         = 1'b0;
      csr_chan.valid         = 1'b0;
      csr_chan.data          = '0;
      no_idle = 1'b0;
      for (int n = 0; n < NODE_COUNT; n++) shadow_tree[n] = bta_pkg::FREE_MARK;
      shadow_levels = TREE_LEVELS;
      shadow_units  = bta_pkg::UNIT_COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // out of reset: full tree, all free
      queue_cmd(bta_pkg::OP_ALLOC, 1, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 0, 1023);        // zero request counts as one unit
      queue_cmd(bta_pkg::OP_ALLOC, 3, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 1024, 0);        // no longer fits
      queue_cmd(bta_pkg::OP_ALLOC, 2047, 0);        // larger than the tree
      queue_cmd(bta_pkg::OP_FREE, 2047, 1);
      queue_cmd(bta_pkg::OP_FREE, 0, 4);
      queue_cmd(OP_UNDEFINED, 2047, 1023);
      queue_cmd(bta_pkg::OP_FREE, 0, 1000);         // no used ancestor: root cleared
      queue_cmd(bta_pkg::OP_ALLOC, 1024, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 1, 0);
      queue_cmd(bta_pkg::OP_FREE, 0, 517);
      queue_cmd(bta_pkg::OP_ALLOC, 512, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 512, 0);
      settle();

      // empty tree: single used node
      set_unit_count(11'd0);
      queue_cmd(bta_pkg::OP_INIT, 0, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 1, 0);
      queue_cmd(bta_pkg::OP_FREE, 0, 1);            // out of range
      queue_cmd(bta_pkg::OP_FREE, 0, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 1, 0);
      settle();

      set_unit_count(11'd5);
      queue_cmd(bta_pkg::OP_INIT, 0, 0);
      queue_cmd(bta_pkg::OP_FREE, 0, 6);            // padding unit
      queue_cmd(bta_pkg::OP_ALLOC, 2, 0);
      queue_cmd(bta_pkg::OP_FREE, 0, 1023);
      settle();

      set_unit_count(11'd2047);                     // saturates at the tree size
      queue_cmd(bta_pkg::OP_INIT, 0, 0);
      queue_cmd(bta_pkg::OP_ALLOC, 1024, 0);

      for (int p = 0; p < 10; p++) begin
         setting = plan[p];
         if (p == 8) setting = bta_pkg::COUNT_W'($urandom_range(4, 1023));
         settle();
         set_unit_count(setting);
         no_idle = (p % 3 == 1);
         queue_cmd(bta_pkg::OP_INIT, 0, 0);
         run_random((setting == 0) ? 40 : 170);
      end

      settle();
      repeat (64) @(posedge clock);
      $display("Ran %0d items over %0d unit_count settings, %0d results checked",
               items_queued, settings_used, results_seen);
      $display("alloc %0d (%0d granted), free %0d (%0d ok), init %0d, bad opcode %0d",
               alloc_total, alloc_granted, free_total, free_ok, init_total, undef_total);
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[buddy_tree_allocator.f]
rtl/bta_pkg.sv
rtl/bta_if.sv
rtl/bta_ram.sv
rtl/buddy_tree_allocator.sv
verif/tb_buddy_tree_allocator.sv
